/* hdl/i2c_master_bit_sequencer_unit_assert.svh */
// ---------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Concurrent assertion shorthands clocked on clock, qualified by reset but for the _RST one.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define MBS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent on the following edge, out of reset
`define MBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// antecedent implies consequent on the following edge, also during reset
`define MBS_ASSERT_NEXT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/i2c_mbs_pkg.sv */
// ---------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared types, codes and phase tables of the open-drain line sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2c_mbs_pkg;

   localparam int BITS_PER_BYTE   = 8;
   localparam int PHASE_W         = 5;
   localparam int TICK_W          = 16;
   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 16;
   localparam int CMD_W           = 3;
   localparam logic [TICK_W-1:0] TICKS_RESET = 16'd10;

   // phase counts per command
   localparam logic [PHASE_W-1:0] WRITE_BIT_PHASES = PHASE_W'(3 * BITS_PER_BYTE);
   localparam logic [PHASE_W-1:0] WRITE_PHASES     = PHASE_W'(3 * BITS_PER_BYTE + 3);
   localparam logic [PHASE_W-1:0] READ_PHASES      = PHASE_W'(2 * BITS_PER_BYTE);
   localparam logic [PHASE_W-1:0] SHORT_PHASES     = PHASE_W'(4);
   // phase of the write ack slot (scl high after sda release)
   localparam logic [PHASE_W-1:0] WRITE_ACK_PHASE  = PHASE_W'(3 * BITS_PER_BYTE + 1);
   localparam logic [PHASE_W-1:0] WRITE_REL_PHASE  = PHASE_W'(3 * BITS_PER_BYTE);

   // command codes on the request channel
   typedef enum logic [CMD_W-1:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_ACK   = 3'd5,
      CMD_NACK  = 3'd6
   } cmd_type;

   // sequencer state, one-hot
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_START = 7'b0000010,
      ST_STOP  = 7'b0000100,
      ST_WRITE = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_ACK   = 7'b0100000,
      ST_NACK  = 7'b1000000
   } state_type;

   // line action: bit 1 picks the line (0 scl, 1 sda), bit 0 the level
   typedef enum logic [1:0] {
      ACT_SCL0 = 2'd0,
      ACT_SCL1 = 2'd1,
      ACT_SDA0 = 2'd2,
      ACT_SDA1 = 2'd3
   } act_type;

   // one result item
   typedef struct packed {
      logic       rejected;
      logic       ack_received;
      logic [7:0] read_data;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } res_type;

   // number of phases of an operation
   function automatic logic [PHASE_W-1:0] phase_total(state_type op);
      logic [PHASE_W-1:0] total;
      unique case (op)
         ST_WRITE: total = WRITE_PHASES;
         ST_READ:  total = READ_PHASES;
         default:  total = SHORT_PHASES;
      endcase
      return total;
   endfunction

   // line action for phase idx of an operation
   function automatic act_type phase_action(state_type op, logic [PHASE_W-1:0] idx,
                                            logic [7:0] tx);
      logic [8:0]         prod;
      logic [2:0]         bit_num;
      logic [PHASE_W-1:0] rem;
      act_type            act;
      // idx / 3 as (idx * 11) >> 5, exact below 3 * BITS_PER_BYTE
      prod    = {4'b0, idx} * 9'd11;
      bit_num = prod[7:5];
      rem     = idx - ({2'b0, bit_num} + {1'b0, bit_num, 1'b0});
      act     = ACT_SCL0;
      unique case (op)
         ST_WRITE: begin
            if (idx < WRITE_BIT_PHASES) begin
               if (rem == 5'd0) begin
                  act = tx[3'(BITS_PER_BYTE - 1) - bit_num] ? ACT_SDA1 : ACT_SDA0;
               end else if (rem == 5'd1) begin
                  act = ACT_SCL1;
               end else begin
                  act = ACT_SCL0;
               end
            end else if (idx == WRITE_REL_PHASE) begin
               act = ACT_SDA1;
            end else if (idx == WRITE_ACK_PHASE) begin
               act = ACT_SCL1;
            end else begin
               act = ACT_SCL0;
            end
         end
         ST_READ: act = idx[0] ? ACT_SCL0 : ACT_SCL1;
         ST_START: begin
            unique case (idx[1:0])
               2'd0: act = ACT_SDA1;
               2'd1: act = ACT_SCL1;
               2'd2: act = ACT_SDA0;
               default: act = ACT_SCL0;
            endcase
         end
         ST_STOP: begin
            unique case (idx[1:0])
               2'd0: act = ACT_SCL0;
               2'd1: act = ACT_SDA0;
               2'd2: act = ACT_SCL1;
               default: act = ACT_SDA1;
            endcase
         end
         ST_ACK: begin
            unique case (idx[1:0])
               2'd0: act = ACT_SCL0;
               2'd1: act = ACT_SDA0;
               2'd2: act = ACT_SCL1;
               default: act = ACT_SCL0;
            endcase
         end
         ST_NACK: begin
            unique case (idx[1:0])
               2'd0: act = ACT_SCL0;
               2'd1: act = ACT_SDA1;
               2'd2: act = ACT_SCL1;
               default: act = ACT_SCL0;
            endcase
         end
         default: act = ACT_SCL0;
      endcase
      return act;
   endfunction

endpackage

/* hdl/i2c_mbs_core.sv */
// ---------------------------------------------------------------------------
// I2C master bit sequencer core
// Phase sequencer state and the per-tick next-state and result logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_mbs_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [i2c_mbs_pkg::CMD_W-1:0]  cmd,
   input  logic [7:0]                     wdata,
   input  logic                           sda_in,
   input  logic [i2c_mbs_pkg::TICK_W-1:0] ticks_per_phase,
   output i2c_mbs_pkg::res_type           res_in
);

   i2c_mbs_pkg::state_type                 op_ff, op_in;
   logic [i2c_mbs_pkg::PHASE_W-1:0]        phase_ff, phase_in;
   logic [i2c_mbs_pkg::TICK_W-1:0]         tick_ff, tick_in;
   logic [7:0]                             shift_ff, shift_in;
   logic [7:0]                             tx_ff, tx_in;
   logic                                   scl_ff, scl_in;
   logic                                   sda_ff, sda_in_lvl;
   logic                                   ack_ff, ack_in;

   logic [i2c_mbs_pkg::TICK_W-1:0]         limit;
   logic [i2c_mbs_pkg::TICK_W-1:0]         tick_sum;
   logic [i2c_mbs_pkg::PHASE_W-1:0]        phase_inc;
   i2c_mbs_pkg::act_type                   act;
   logic                                   apply;
   logic                                   done;
   logic                                   rej;

   // zero period runs as one tick
   assign limit     = (ticks_per_phase == '0) ? i2c_mbs_pkg::TICK_W'(1) : ticks_per_phase;
   assign tick_sum  = tick_ff + i2c_mbs_pkg::TICK_W'(1);
   assign phase_inc = phase_ff + i2c_mbs_pkg::PHASE_W'(1);

   // next state for one tick
   always_comb begin
      op_in      = op_ff;
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      shift_in   = shift_ff;
      tx_in      = tx_ff;
      scl_in     = scl_ff;
      sda_in_lvl = sda_ff;
      ack_in     = ack_ff;
      act        = i2c_mbs_pkg::ACT_SCL0;
      apply      = 1'b0;
      done       = 1'b0;
      rej        = 1'b0;
      if (op_ff != i2c_mbs_pkg::ST_IDLE) begin
         rej = (cmd != i2c_mbs_pkg::CMD_NONE);
         if (tick_sum >= limit) begin
            // samples taken as the phase ends
            if (op_ff == i2c_mbs_pkg::ST_WRITE && phase_ff == i2c_mbs_pkg::WRITE_ACK_PHASE) begin
               ack_in = sda_in;
            end
            if (op_ff == i2c_mbs_pkg::ST_READ && !phase_ff[0]) begin
               shift_in = {shift_ff[6:0], sda_in};
            end
            tick_in = '0;
            if (phase_inc >= i2c_mbs_pkg::phase_total(op_ff)) begin
               done     = 1'b1;
               op_in    = i2c_mbs_pkg::ST_IDLE;
               phase_in = '0;
            end else begin
               phase_in = phase_inc;
               act      = i2c_mbs_pkg::phase_action(op_ff, phase_inc, tx_ff);
               apply    = 1'b1;
            end
         end else begin
            tick_in = tick_sum;
         end
      end else begin
         // command decode while idle
         unique case (cmd)
            i2c_mbs_pkg::CMD_START: op_in = i2c_mbs_pkg::ST_START;
            i2c_mbs_pkg::CMD_STOP:  op_in = i2c_mbs_pkg::ST_STOP;
            i2c_mbs_pkg::CMD_WRITE: op_in = i2c_mbs_pkg::ST_WRITE;
            i2c_mbs_pkg::CMD_READ:  op_in = i2c_mbs_pkg::ST_READ;
            i2c_mbs_pkg::CMD_ACK:   op_in = i2c_mbs_pkg::ST_ACK;
            i2c_mbs_pkg::CMD_NACK:  op_in = i2c_mbs_pkg::ST_NACK;
            default:                op_in = i2c_mbs_pkg::ST_IDLE;
         endcase
         if (op_in != i2c_mbs_pkg::ST_IDLE) begin
            phase_in = '0;
            tick_in  = '0;
            if (op_in == i2c_mbs_pkg::ST_WRITE) begin
               tx_in = wdata;
            end
            if (op_in == i2c_mbs_pkg::ST_READ) begin
               shift_in   = '0;
               sda_in_lvl = 1'b1;
            end
            act   = i2c_mbs_pkg::phase_action(op_in, '0, tx_in);
            apply = 1'b1;
         end
      end
      // drive the selected line
      if (apply) begin
         if (act[1]) begin
            sda_in_lvl = act[0];
         end else begin
            scl_in = act[0];
         end
      end
   end

   // result of this tick
   always_comb begin
      res_in.scl_out      = scl_in;
      res_in.sda_out      = sda_in_lvl;
      res_in.busy_res     = (op_in != i2c_mbs_pkg::ST_IDLE);
      res_in.done_res     = done;
      res_in.read_data    = shift_in;
      res_in.ack_received = ack_in;
      res_in.rejected     = rej;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= i2c_mbs_pkg::ST_IDLE;
         phase_ff <= '0;
         tick_ff  <= '0;
         shift_ff <= '0;
         tx_ff    <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
      end else if (advance) begin
         op_ff    <= op_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
         tx_ff    <= tx_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_lvl;
         ack_ff   <= ack_in;
      end
   end

endmodule

/* hdl/i2c_master_bit_sequencer_unit.sv */
// ---------------------------------------------------------------------------
// I2C master bit sequencer
// Open-drain I2C master line sequencer driven by one request per time tick.
// ---------------------------------------------------------------------------
// Each request is one timebase tick carrying an optional command (start,
// stop, write byte, read byte, send ack, send nack) and the sampled SDA
// level; each request yields exactly one response with the SCL and SDA
// drive levels, busy and done flags, the read byte, the write ack bit and a
// rejected flag for commands given while busy. One request is taken every
// clock cycle unless a stalled response fills the output register; each
// response is registered there, the only stage, so a stalled one holds off
// requests only until taken. Every line phase lasts ticks_per_phase ticks
// (zero counts as one), which the user must write on the csr port while the
// sequencer is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [i2c_mbs_pkg::REQ_DATA_W-1:0]  req_tdata,  // write_data[7:0], sda_in[8]
   input  logic [i2c_mbs_pkg::CMD_W-1:0]       req_tuser,  // command[2:0]
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
   // ack_received[12], rejected[13]
   output logic [i2c_mbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [i2c_mbs_pkg::TICK_W-1:0]      csr_wr_data
);

   logic                                 accept;
   logic                                 rsp_valid_ff, rsp_valid_in;
   i2c_mbs_pkg::res_type                 rsp_res_ff;
   i2c_mbs_pkg::res_type                 res_in;
   logic [i2c_mbs_pkg::TICK_W-1:0]       ticks_ff;

   // request taken when the output register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= i2c_mbs_pkg::TICKS_RESET;
      end else if (csr_wr_en) begin
         ticks_ff <= csr_wr_data;
      end
   end

   i2c_mbs_core u_core (
      .clock           (clock),
      .reset           (reset),
      .advance         (accept),
      .cmd             (req_tuser),
      .wdata           (req_tdata[7:0]),
      .sda_in          (req_tdata[8]),
      .ticks_per_phase (ticks_ff),
      .res_in          (res_in)
   );

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_res_ff};

endmodule

/* hdl/i2c_mbs_checker.sv */
// ---------------------------------------------------------------------------
// I2C master bit sequencer checker
// Port-level assertions on the sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_unit_assert.svh"

module i2c_mbs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [i2c_mbs_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // no response is pending right after reset
   `MBS_ASSERT_NEXT_RST(a_reset_empty, reset, !rsp_tvalid, "response valid after reset")

   // an empty output register never stalls requests
   `MBS_ASSERT_ALWAYS(a_ready_when_empty, !rsp_tvalid -> req_tready, "request stalled while empty")

   // an accepted request always produces a response on the next edge
   `MBS_ASSERT_NEXT(a_rsp_follows, req_tvalid && req_tready, rsp_tvalid, "request lost")

   // the done tick ends the sequence, so busy is clear with it
   `MBS_ASSERT_ALWAYS(a_done_not_busy, !(rsp_tvalid && rsp_tdata[3] && rsp_tdata[2]), "done while busy")

   // a stalled response holds
   `MBS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

endmodule

bind i2c_master_bit_sequencer_unit i2c_mbs_checker u_i2c_mbs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);
